// ===== sv/scfr_pkg.sv =====
// Shared types and constants of the sum-checked frame receiver.
package scfr_pkg;

    localparam logic [7:0] HDR_FIRST   = 8'hCA;
    localparam logic [7:0] HDR_SECOND  = 8'hCF;
    localparam logic [7:0] ID_LIMIT    = 8'hF1;
    localparam logic [7:0] LEN_INVALID = 8'hFF;

    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_HDR2 = 3'd1;
    localparam logic [2:0] PH_ID   = 3'd2;
    localparam logic [2:0] PH_LEN  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_SUM  = 3'd5;

    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_END_GOOD = 2'd1;
    localparam logic [1:0] KIND_END_BAD  = 2'd2;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data_byte;
        logic [7:0] frame_id;
        logic [7:0] payload_index;
        logic       last;
    } t_result;

endpackage

// ===== sv/scfr_decoder.sv =====
// Frame state machine: header hunt, id, length, payload and checksum check.
module scfr_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  logic [7:0]          i_byte,
    output logic                o_has_result,
    output scfr_pkg::t_result   o_result
);

    logic [2:0] r_phase, n_phase;
    logic [7:0] r_id, n_id;
    logic [7:0] r_left, n_left;
    logic [7:0] r_count, n_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] sum_plus;

    assign sum_plus = r_sum + i_byte;

    always_comb begin
        n_phase      = scfr_pkg::PH_HUNT;
        n_id         = r_id;
        n_left       = r_left;
        n_count      = r_count;
        n_sum        = r_sum;
        o_has_result = 1'b0;
        o_result.kind          = scfr_pkg::KIND_PAYLOAD;
        o_result.data_byte     = i_byte;
        o_result.frame_id      = r_id;
        o_result.payload_index = r_count;
        o_result.last          = 1'b0;
        unique case (r_phase)
            scfr_pkg::PH_HUNT: begin
                if (i_byte == scfr_pkg::HDR_FIRST) begin
                    n_phase = scfr_pkg::PH_HDR2;
                    n_sum   = i_byte;
                end
            end
            scfr_pkg::PH_HDR2: begin
                if (i_byte == scfr_pkg::HDR_SECOND) begin
                    n_phase = scfr_pkg::PH_ID;
                    n_sum   = sum_plus;
                end
            end
            scfr_pkg::PH_ID: begin
                if (i_byte != 8'd0 && i_byte < scfr_pkg::ID_LIMIT) begin
                    n_phase = scfr_pkg::PH_LEN;
                    n_id    = i_byte;
                    n_sum   = sum_plus;
                end
            end
            scfr_pkg::PH_LEN: begin
                if (i_byte != scfr_pkg::LEN_INVALID) begin
                    n_phase = scfr_pkg::PH_DATA;
                    n_left  = i_byte;
                    n_count = 8'd0;
                    n_sum   = sum_plus;
                end
            end
            scfr_pkg::PH_DATA: begin
                if (r_left != 8'd0) begin
                    o_has_result = 1'b1;
                    n_left       = r_left - 8'd1;
                    n_count      = r_count + 8'd1;
                    n_sum        = sum_plus;
                    n_phase      = (r_left == 8'd1) ? scfr_pkg::PH_SUM : scfr_pkg::PH_DATA;
                end
            end
            scfr_pkg::PH_SUM: begin
                o_has_result  = 1'b1;
                o_result.kind = (i_byte == r_sum) ? scfr_pkg::KIND_END_GOOD
                                                  : scfr_pkg::KIND_END_BAD;
                o_result.last = 1'b1;
            end
            default: begin
                n_phase = scfr_pkg::PH_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= scfr_pkg::PH_HUNT;
            r_id    <= 8'd0;
            r_left  <= 8'd0;
            r_count <= 8'd0;
            r_sum   <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_id    <= n_id;
            r_left  <= n_left;
            r_count <= n_count;
            r_sum   <= n_sum;
        end
    end

endmodule

// ===== sv/scfr_out_reg.sv =====
// Result register that holds a beat until the consumer takes it.
module scfr_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  scfr_pkg::t_result   i_result,
    input  logic                i_stall,
    output logic                o_valid,
    output scfr_pkg::t_result   o_result
);

    logic              r_valid;
    scfr_pkg::t_result r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== sv/sum_checked_frame_receiver.sv =====
// Top level of the sum-checked frame receiver.
// Takes one stream byte per cycle unless o_in_stall holds it, and gives at most one result
// beat per byte: a payload beat for each payload byte, and a frame-end beat with good or bad
// status on the checksum byte of a frame of nonzero length. An accepted byte waits in the
// input register and passes through the frame state machine into the result register; the
// machine's single state update per byte sets that rate. Payload beats leave before the
// checksum is known, so a consumer must drop the payload of a frame that ends bad.
module sum_checked_frame_receiver (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_kind,
    output logic [7:0] o_data_byte,
    output logic [7:0] o_frame_id,
    output logic [7:0] o_payload_index,
    output logic       o_last
);

    logic              r_in_valid;
    logic [7:0]        r_in_byte;
    logic              has_result;
    logic              out_free;
    logic              advance;
    scfr_pkg::t_result dec_result;
    scfr_pkg::t_result out_result;

    assign out_free   = !o_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!has_result || out_free);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_in_byte;
        end
    end

    scfr_decoder u_decoder (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (advance),
        .i_byte       (r_in_byte),
        .o_has_result (has_result),
        .o_result     (dec_result)
    );

    scfr_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && has_result),
        .i_result (dec_result),
        .i_stall  (i_out_stall),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_kind          = out_result.kind;
    assign o_data_byte     = out_result.data_byte;
    assign o_frame_id      = out_result.frame_id;
    assign o_payload_index = out_result.payload_index;
    assign o_last          = out_result.last;

    a_last_marks_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_last == (o_kind != scfr_pkg::KIND_PAYLOAD)))
        else $error("last flag disagrees with result kind");

    a_kind_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_kind == scfr_pkg::KIND_PAYLOAD ||
                         o_kind == scfr_pkg::KIND_END_GOOD ||
                         o_kind == scfr_pkg::KIND_END_BAD))
        else $error("illegal result kind");

    a_id_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_frame_id != 8'd0 && o_frame_id < scfr_pkg::ID_LIMIT))
        else $error("result beat carries an out-of-range frame id");

    a_in_reg_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && o_in_stall) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("stalled input byte was lost or changed");

endmodule

// ===== tb/sum_checked_frame_receiver_tb.sv =====
// Self-checking testbench for the sum-checked frame receiver, with a built-in deframing predictor.
module sum_checked_frame_receiver_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 1450;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int QUIET_TAIL   = 200;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 100;

    logic       i_clk;
    logic       i_rst_n         = 1'b0;
    logic       i_in_valid      = 1'b0;
    logic [7:0] i_in_byte       = 8'h00;
    logic       i_out_stall     = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [1:0] o_kind;
    logic [7:0] o_data_byte;
    logic [7:0] o_frame_id;
    logic [7:0] o_payload_index;
    logic       o_last;

    sum_checked_frame_receiver i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_in_byte      (i_in_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_kind         (o_kind),
        .o_data_byte    (o_data_byte),
        .o_frame_id     (o_frame_id),
        .o_payload_index(o_payload_index),
        .o_last         (o_last)
    );

    logic [7:0]        stream_bytes[$];
    scfr_pkg::t_result expected_beats[$];

    int          beats_in    = 0;
    int          idle_end    = 0;
    int          send_gap    = 0;
    int          stall_gap   = 0;
    int          hold_left   = 0;
    bit          hold_done   = 1'b0;
    int          mismatches  = 0;
    int unsigned cycle_count = 0;

    logic [2:0] rx_phase    = scfr_pkg::PH_HUNT;
    logic [7:0] rx_id       = 8'h00;
    logic [7:0] rx_left     = 8'h00;
    logic [7:0] rx_count    = 8'h00;
    logic [7:0] rx_sum      = 8'h00;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advances the deframer state by one byte and reports the beat it produces, if any.
    function automatic bit deframe_byte(input logic [7:0] b, output scfr_pkg::t_result beat);
        beat = '0;
        if (rx_phase == scfr_pkg::PH_HUNT && b == scfr_pkg::HDR_FIRST) begin
            rx_phase = scfr_pkg::PH_HDR2;
            rx_sum   = b;
            return 1'b0;
        end
        if (rx_phase == scfr_pkg::PH_HDR2 && b == scfr_pkg::HDR_SECOND) begin
            rx_phase = scfr_pkg::PH_ID;
            rx_sum   = rx_sum + b;
            return 1'b0;
        end
        if (rx_phase == scfr_pkg::PH_ID && b != 8'h00 && b < scfr_pkg::ID_LIMIT) begin
            rx_phase = scfr_pkg::PH_LEN;
            rx_id    = b;
            rx_sum   = rx_sum + b;
            return 1'b0;
        end
        if (rx_phase == scfr_pkg::PH_LEN && b != scfr_pkg::LEN_INVALID) begin
            rx_phase = scfr_pkg::PH_DATA;
            rx_left  = b;
            rx_count = 8'h00;
            rx_sum   = rx_sum + b;
            return 1'b0;
        end
        if (rx_phase == scfr_pkg::PH_DATA && rx_left != 8'h00) begin
            beat.kind          = scfr_pkg::KIND_PAYLOAD;
            beat.data_byte     = b;
            beat.frame_id      = rx_id;
            beat.payload_index = rx_count;
            beat.last          = 1'b0;
            rx_left  = rx_left - 8'd1;
            rx_count = rx_count + 8'd1;
            rx_sum   = rx_sum + b;
            if (rx_left == 8'h00) begin
                rx_phase = scfr_pkg::PH_SUM;
            end
            return 1'b1;
        end
        if (rx_phase == scfr_pkg::PH_SUM) begin
            rx_phase           = scfr_pkg::PH_HUNT;
            beat.kind          = (b == rx_sum) ? scfr_pkg::KIND_END_GOOD
                                               : scfr_pkg::KIND_END_BAD;
            beat.data_byte     = b;
            beat.frame_id      = rx_id;
            beat.payload_index = rx_count;
            beat.last          = 1'b1;
            return 1'b1;
        end
        rx_phase = scfr_pkg::PH_HUNT;
        return 1'b0;
    endfunction

    function automatic bit idle_allowed(input int count);
        return count < idle_end && (count / 160) % 4 != 3;
    endfunction

    // Queues a frame around the given payload, optionally with a wrong checksum and cut short.
    task automatic queue_frame(input logic [7:0] id, input logic [7:0] body[$],
                               input bit good_sum, input int keep);
        logic [7:0] frame_q[$];
        logic [7:0] sum;
        int         n;
        frame_q = {scfr_pkg::HDR_FIRST, scfr_pkg::HDR_SECOND, id, 8'(body.size())};
        frame_q = {frame_q, body};
        sum = 8'h00;
        foreach (frame_q[k]) sum = sum + frame_q[k];
        frame_q.push_back(good_sum ? sum : sum + 8'($urandom_range(1, 255)));
        n = (keep < 0 || keep > frame_q.size()) ? frame_q.size() : keep;
        for (int k = 0; k < n; k++) stream_bytes.push_back(frame_q[k]);
    endtask

    task automatic queue_random_body(output logic [7:0] body[$], input int len);
        body = {};
        for (int k = 0; k < len; k++) body.push_back(8'($urandom_range(0, 255)));
    endtask

    initial begin
        logic [7:0] body[$];
        logic [7:0] id;
        logic [7:0] b;
        int         frames;
        int         pick;
        int         len;
        int         directed_count;

        queue_frame(8'd1, '{8'h00, 8'hFF}, 1'b1, -1);
        // A zero-length frame drops the byte after it, even a first header byte.
        stream_bytes = {stream_bytes, scfr_pkg::HDR_FIRST, scfr_pkg::HDR_SECOND, 8'd240,
                        8'h00, scfr_pkg::HDR_FIRST};
        queue_frame(8'h7E, '{8'hA5}, 1'b0, -1);
        stream_bytes = {stream_bytes, scfr_pkg::HDR_FIRST, scfr_pkg::HDR_FIRST};
        stream_bytes = {stream_bytes, scfr_pkg::HDR_FIRST, scfr_pkg::HDR_SECOND, 8'h00};
        stream_bytes = {stream_bytes, scfr_pkg::HDR_FIRST, scfr_pkg::HDR_SECOND,
                        scfr_pkg::ID_LIMIT};
        stream_bytes = {stream_bytes, scfr_pkg::HDR_FIRST, scfr_pkg::HDR_SECOND, 8'h07,
                        scfr_pkg::LEN_INVALID};
        directed_count = stream_bytes.size();

        frames = 0;
        while (stream_bytes.size() < directed_count + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 76) begin
                if (frames == 6 || frames == 45) begin
                    len = 254;
                end else if ($urandom_range(0, 9) == 0) begin
                    len = $urandom_range(13, 60);
                end else begin
                    len = $urandom_range(0, 12);
                end
                case ($urandom_range(0, 9))
                    0: id = 8'd1;
                    1: id = 8'd240;
                    default: id = 8'($urandom_range(1, 240));
                endcase
                queue_random_body(body, len);
                queue_frame(id, body, $urandom_range(0, 99) < 85, -1);
                frames++;
            end else if (pick < 88) begin
                case ($urandom_range(0, 3))
                    0: begin
                        len = $urandom_range(0, 12);
                        queue_random_body(body, len);
                        queue_frame(8'($urandom_range(1, 240)), body, 1'b1,
                                    $urandom_range(1, len + 4));
                    end
                    1: begin
                        b = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(241, 255));
                        stream_bytes = {stream_bytes, scfr_pkg::HDR_FIRST,
                                        scfr_pkg::HDR_SECOND, b};
                    end
                    2: begin
                        stream_bytes = {stream_bytes, scfr_pkg::HDR_FIRST,
                                        scfr_pkg::HDR_SECOND, 8'($urandom_range(1, 240)),
                                        scfr_pkg::LEN_INVALID};
                    end
                    default: begin
                        b = 8'($urandom_range(0, 255));
                        if (b == scfr_pkg::HDR_SECOND) b = 8'hCE;
                        stream_bytes = {stream_bytes, scfr_pkg::HDR_FIRST, b};
                    end
                endcase
            end else begin
                repeat ($urandom_range(1, 4)) stream_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        idle_end = stream_bytes.size() - QUIET_TAIL;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (stream_bytes.size() != 0 || i_in_valid || expected_beats.size() != 0);
        repeat (12) @(negedge i_clk);

        if (mismatches == 0 && expected_beats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    always @(posedge i_clk) begin : byte_driver
        scfr_pkg::t_result beat;
        bit                has_beat;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                has_beat = deframe_byte(i_in_byte, beat);
                if (has_beat) expected_beats.push_back(beat);
                beats_in <= beats_in + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (stream_bytes.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (idle_allowed(beats_in) && hold_left == 0
                             && $urandom_range(0, 99) < 12) begin
                    send_gap = $urandom_range(0, 7);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_valid <= 1'b1;
                    i_in_byte  <= stream_bytes.pop_front();
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_stall <= 1'b1;
        end else if (!hold_done && beats_in >= HOLD_AT) begin
            hold_done   <= 1'b1;
            hold_left   <= HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else if (stall_gap > 0) begin
            stall_gap = stall_gap - 1;
            i_out_stall <= 1'b1;
        end else if (idle_allowed(beats_in) && $urandom_range(0, 99) < 15) begin
            stall_gap = $urandom_range(0, 7);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : result_monitor
        scfr_pkg::t_result got;
        scfr_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.kind          = o_kind;
            got.data_byte     = o_data_byte;
            got.frame_id      = o_frame_id;
            got.payload_index = o_payload_index;
            got.last          = o_last;
            if (expected_beats.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected beat: kind=%0d data=%h id=%0d index=%0d last=%b",
                             got.kind, got.data_byte, got.frame_id, got.payload_index,
                             got.last);
                end
            end else begin
                want = expected_beats.pop_front();
                if (got.kind !== want.kind || got.data_byte !== want.data_byte
                    || got.frame_id !== want.frame_id
                    || got.payload_index !== want.payload_index
                    || got.last !== want.last) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("beat mismatch: expected kind=%0d data=%h id=%0d index=%0d last=%b",
                                 want.kind, want.data_byte, want.frame_id,
                                 want.payload_index, want.last);
                        $display("               actual   kind=%0d data=%h id=%0d index=%0d last=%b",
                                 got.kind, got.data_byte, got.frame_id,
                                 got.payload_index, got.last);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
